FILE: rtl/core/wtrhpc_pkg.sv
// Package with payload types, register indexes and reset values for the watering controller.
package wtrhpc_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_THRESHOLD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LENGTH_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_PERIOD_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_HOLDOFF_MS = 3'd4;

    // Register reset values
    localparam logic [11:0] DRY_THRESHOLD_RST   = 12'd2000;
    localparam logic [11:0] WET_THRESHOLD_RST   = 12'd1500;
    localparam logic [15:0] PULSE_LENGTH_RST    = 16'd2000;
    localparam logic [31:0] REST_PERIOD_RST     = 32'd60000;
    localparam logic [31:0] BOOT_HOLDOFF_RST    = 32'd15000;

    // One evaluation request
    typedef struct packed {
        logic [11:0] moisture;
        logic [31:0] now_ms;
        logic        manual_request;
    } t_in_item;

    // One evaluation result
    typedef struct packed {
        logic pump_drive;
        logic watering_mode;
        logic pulse_started;
    } t_out_item;

endpackage

FILE: rtl/core/watering_hysteresis_pulse_ctrl_core.sv
// Top level of the hysteresis watering controller with timed pump pulses.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// An item is registered on transfer, evaluated combinationally against the controller
// state and lands in the result register once that register is free to take it.
// One item per cycle is sustained while the output is not stalled; the evaluation is one pass of one 32-bit subtract
// and compares. A stalled output holds the result and the input register, and
// o_in_ready drops only while both are full. Reset clears state, registers to defaults.
module watering_hysteresis_pulse_ctrl_core
    import wtrhpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // Configuration registers
    logic [11:0] r_dry_threshold;
    logic [11:0] r_wet_threshold;
    logic [15:0] r_pulse_length;
    logic [31:0] r_rest_period;
    logic [31:0] r_boot_holdoff;

    // Controller state
    logic        r_mode;
    logic        r_pump;
    logic [31:0] r_pulse_start;
    logic        r_ovr;

    // Pipeline registers
    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;

    // Next-state values
    logic        n_mode;
    logic        n_pump;
    logic [31:0] n_pulse_start;
    logic        n_ovr;
    t_out_item   n_out;

    logic        adv_out;
    logic [31:0] since;
    logic        ovr_set;
    logic        mode_in;
    logic        start;
    logic        pump_mid;
    logic        pulse_done;

    assign o_cfg_ready = 1'b1;
    assign adv_out     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv_out;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry_threshold <= DRY_THRESHOLD_RST;
            r_wet_threshold <= WET_THRESHOLD_RST;
            r_pulse_length  <= PULSE_LENGTH_RST;
            r_rest_period   <= REST_PERIOD_RST;
            r_boot_holdoff  <= BOOT_HOLDOFF_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DRY_THRESHOLD:   r_dry_threshold <= i_cfg_data[11:0];
                CFG_WET_THRESHOLD:   r_wet_threshold <= i_cfg_data[11:0];
                CFG_PULSE_LENGTH_MS: r_pulse_length  <= i_cfg_data[15:0];
                CFG_REST_PERIOD_MS:  r_rest_period   <= i_cfg_data;
                CFG_BOOT_HOLDOFF_MS: r_boot_holdoff  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Evaluation of the registered item against the state
    assign since      = r_in.now_ms - r_pulse_start;
    assign ovr_set    = r_ovr || r_in.manual_request;
    assign mode_in    = r_mode || ovr_set;
    assign start      = !r_pump && ((since >= r_rest_period) || (r_pulse_start == 32'd0)
                        || ovr_set);
    assign pump_mid   = r_pump || start;
    // a fresh pulse has zero elapsed time
    assign pulse_done = start ? (r_pulse_length == 16'd0)
                              : (since >= {16'd0, r_pulse_length});

    always_comb begin
        n_mode        = mode_in;
        n_pump        = r_pump;
        n_pulse_start = r_pulse_start;
        n_ovr         = ovr_set;
        n_out.pulse_started = 1'b0;
        if (!mode_in) begin
            n_mode = (r_in.moisture > r_dry_threshold);
        end else begin
            if (r_in.now_ms < r_boot_holdoff) begin
                n_pump = 1'b0;
            end else begin
                if (start) begin
                    n_pulse_start       = r_in.now_ms;
                    n_ovr               = 1'b0;
                    n_out.pulse_started = 1'b1;
                end
                n_pump = pump_mid && !pulse_done;
            end
            if (!n_pump && (r_in.moisture < r_wet_threshold)) begin
                n_mode = 1'b0;
            end
        end
        n_out.pump_drive    = n_pump;
        n_out.watering_mode = n_mode;
    end

    // Controller state and valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= 1'b0;
            r_pump        <= 1'b0;
            r_pulse_start <= 32'd0;
            r_ovr         <= 1'b0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (adv_out) begin
                r_mode        <= n_mode;
                r_pump        <= n_pump;
                r_pulse_start <= n_pulse_start;
                r_ovr         <= n_ovr;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (adv_out) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: rtl/core/wtrhpc_checker.sv
// Port-level checker for the watering controller and its bind to the top level.
module wtrhpc_checker
    import wtrhpc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // A stalled result keeps its valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // The pump only runs in watering mode
    a_pump_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pump_drive |-> o_out_data.watering_mode)
        else $error("pump running while idle");

    // An empty output stage never blocks input
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

endmodule

bind watering_hysteresis_pulse_ctrl_core wtrhpc_checker u_wtrhpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: verif/watering_hysteresis_pulse_ctrl_core_test.sv
// Self-checking testbench for the watering hysteresis pulse controller core.
`timescale 1ns / 1ps

module watering_hysteresis_pulse_ctrl_core_test
    import wtrhpc_pkg::*;
();

    localparam int CLK_HALF     = 10;
    localparam int RST_CYCLES   = 8;
    localparam int LONG_HOLD    = 80;
    // time for the input and result registers to empty, plus margin
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MOIST_MAX    = 4095;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    // Predictor copy of the registers and the controller state
    logic [11:0] dry_lim;
    logic [11:0] wet_lim;
    logic [15:0] pulse_len;
    logic [31:0] rest_ms;
    logic [31:0] holdoff_ms;
    logic        mode_on     = 1'b0;
    logic        pump_on     = 1'b0;
    logic [31:0] pulse_t0    = '0;
    logic        ovr_latched = 1'b0;

    t_in_item  sample_q[$];
    t_out_item outcome_q[$];

    bit          idle_on   = 1'b1;
    bit          in_taken  = 1'b0;
    int          send_gap  = 0;
    int          stall_cnt = 0;
    int          hold_ask  = 0;
    int          hold_seen = 0;
    int          err_cnt   = 0;
    int          cycle_cnt = 0;
    int          soil      = 2000;
    logic [31:0] sim_ms    = '0;

    watering_hysteresis_pulse_ctrl_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Register write into the predictor; unknown indexes are dropped
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        case (idx)
            CFG_DRY_THRESHOLD:   dry_lim    = val[11:0];
            CFG_WET_THRESHOLD:   wet_lim    = val[11:0];
            CFG_PULSE_LENGTH_MS: pulse_len  = val[15:0];
            CFG_REST_PERIOD_MS:  rest_ms    = val;
            CFG_BOOT_HOLDOFF_MS: holdoff_ms = val;
            default: ;
        endcase
    endfunction

    // One evaluation: override latch, hysteresis mode, boot hold-off, pulse timing
    function automatic t_out_item water_eval(input t_in_item it);
        t_out_item   res;
        logic [31:0] since;
        res = '0;
        if (it.manual_request) ovr_latched = 1'b1;
        if (ovr_latched) mode_on = 1'b1;
        if (!mode_on) begin
            if (it.moisture > dry_lim) mode_on = 1'b1;
        end else begin
            if (it.now_ms < holdoff_ms) begin
                pump_on = 1'b0;
            end else begin
                if (!pump_on) begin
                    since = it.now_ms - pulse_t0;
                    if (since >= rest_ms || pulse_t0 == '0 || ovr_latched) begin
                        pump_on           = 1'b1;
                        pulse_t0          = it.now_ms;
                        ovr_latched       = 1'b0;
                        res.pulse_started = 1'b1;
                    end
                end
                since = it.now_ms - pulse_t0;
                if (pump_on && since >= 32'(pulse_len)) pump_on = 1'b0;
            end
            if (!pump_on && it.moisture < wet_lim) mode_on = 1'b0;
        end
        res.pump_drive    = pump_on;
        res.watering_mode = mode_on;
        return res;
    endfunction

    // Input side: offer queued samples, random gaps between them
    always @(negedge clk) begin : drive_samples
        logic     nxt_valid;
        t_in_item nxt_data;
        nxt_valid = in_valid;
        nxt_data  = in_data;
        if (!in_valid || in_taken) begin
            nxt_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (sample_q.size() > 0) begin
                nxt_valid = 1'b1;
                nxt_data  = sample_q.pop_front();
                if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 10);
            end
        end
        in_valid <= nxt_valid;
        in_data  <= nxt_data;
    end

    // Output side: ready with random stall bursts and the occasional long hold
    always @(negedge clk) begin : drive_ready
        logic nxt;
        if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            stall_cnt = LONG_HOLD;
        end
        if (stall_cnt > 0) begin
            stall_cnt--;
            nxt = 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_cnt = $urandom_range(1, 10) - 1;
            nxt       = 1'b0;
        end else begin
            nxt = 1'b1;
        end
        out_ready <= nxt;
    end

    // Predict on each input transfer, compare each output transfer
    always @(posedge clk) begin : check_results
        t_out_item want;
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken) outcome_q.push_back(water_eval(in_data));
        if (rst_n && out_valid && out_ready) begin
            if (outcome_q.size() == 0) begin
                $error("result transfer with no evaluation pending: %b", out_data);
                err_cnt++;
            end else begin
                want = outcome_q.pop_front();
                if (out_data.pump_drive !== want.pump_drive) begin
                    $error("pump_drive: expected %0b, got %0b", want.pump_drive,
                           out_data.pump_drive);
                    err_cnt++;
                end
                if (out_data.watering_mode !== want.watering_mode) begin
                    $error("watering_mode: expected %0b, got %0b", want.watering_mode,
                           out_data.watering_mode);
                    err_cnt++;
                end
                if (out_data.pulse_started !== want.pulse_started) begin
                    $error("pulse_started: expected %0b, got %0b", want.pulse_started,
                           out_data.pulse_started);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [31:0] dry, input logic [31:0] wet,
                            input logic [31:0] plen, input logic [31:0] rest,
                            input logic [31:0] hold);
        cfg_write(CFG_DRY_THRESHOLD, dry);
        cfg_write(CFG_WET_THRESHOLD, wet);
        cfg_write(CFG_PULSE_LENGTH_MS, plen);
        cfg_write(CFG_REST_PERIOD_MS, rest);
        cfg_write(CFG_BOOT_HOLDOFF_MS, hold);
    endtask

    // Wait until nothing is offered or outstanding, then let the pipe settle
    task automatic wait_drained();
        while (sample_q.size() != 0 || in_valid || outcome_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_one(input int moist, input logic [31:0] now, input bit req);
        t_in_item it;
        it.moisture       = 12'(moist);
        it.now_ms         = now;
        it.manual_request = req;
        sample_q.push_back(it);
    endtask

    // Time mostly runs forward in small steps; the sensor drifts across both thresholds
    task automatic push_run(input int n, input int max_step);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 31))
                0:       sim_ms = $urandom;
                1:       sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * max_step);
                default: sim_ms = sim_ms + $urandom_range(0, max_step);
            endcase
            case ($urandom_range(0, 15))
                0:       soil = 0;
                1:       soil = MOIST_MAX;
                2:       soil = $urandom_range(0, MOIST_MAX);
                default: soil = soil + int'($urandom_range(0, 400)) - 200;
            endcase
            if (soil < 0) soil = 0;
            if (soil > MOIST_MAX) soil = MOIST_MAX;
            push_one(soil, sim_ms, $urandom_range(0, 15) == 0);
        end
    endtask

    initial begin : stimulus
        logic [11:0] dry_pick;
        apply_reg(CFG_DRY_THRESHOLD, 32'(DRY_THRESHOLD_RST));
        apply_reg(CFG_WET_THRESHOLD, 32'(WET_THRESHOLD_RST));
        apply_reg(CFG_PULSE_LENGTH_MS, 32'(PULSE_LENGTH_RST));
        apply_reg(CFG_REST_PERIOD_MS, REST_PERIOD_RST);
        apply_reg(CFG_BOOT_HOLDOFF_MS, BOOT_HOLDOFF_RST);
        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset defaults: moisture entry, boot hold-off, latched override, pulse timing
        push_one(MOIST_MAX, 32'd0, 1'b0);
        push_one(MOIST_MAX, 32'd100, 1'b0);
        push_one(MOIST_MAX, 32'd200, 1'b1);
        push_one(3000, 32'd15000, 1'b0);
        push_one(3000, 32'd16000, 1'b0);
        push_one(3000, 32'd17000, 1'b0);
        push_one(0, 32'd17001, 1'b0);
        push_one(0, 32'd20000, 1'b1);
        push_one(0, 32'd20100, 1'b0);
        push_one(0, 32'hFFFF_F000, 1'b0);
        wait_drained();

        // Spare indexes must not disturb anything
        for (int ix = CFG_BOOT_HOLDOFF_MS + 1; ix < (1 << CFG_IDX_W); ix++)
            cfg_write(CFG_IDX_W'(ix), $urandom);

        // Extremes: pulse at time zero, zero-length pulses
        set_regs(32'd0, 32'd4095, 32'd0, 32'd0, 32'd0);
        push_one(MOIST_MAX, 32'd0, 1'b0);
        push_one(MOIST_MAX, 32'd0, 1'b0);
        push_one(MOIST_MAX, 32'd0, 1'b0);
        push_one(0, 32'd0, 1'b0);
        wait_drained();

        // Time wrap during a pulse and during the rest period
        set_regs(32'd2048, 32'd1024, 32'd100, 32'd500, 32'd0);
        push_one(MOIST_MAX, 32'hFFFF_FFC0, 1'b0);
        push_one(MOIST_MAX, 32'hFFFF_FFE0, 1'b0);
        push_one(MOIST_MAX, 32'h0000_0010, 1'b0);
        push_one(MOIST_MAX, 32'h0000_0050, 1'b0);
        push_one(MOIST_MAX, 32'h0000_0100, 1'b0);
        push_one(MOIST_MAX, 32'h0000_0200, 1'b0);
        push_one(1024, 32'h0000_0300, 1'b0);
        push_one(1023, 32'h0000_0301, 1'b0);
        push_one(2048, 32'h0000_0302, 1'b0);
        push_one(2049, 32'h0000_0303, 1'b0);
        wait_drained();

        // Short pulses and rest, small hold-off; long receiver hold while offering
        set_regs(32'd2048, 32'd1024, 32'd8, 32'd40, 32'd200);
        sim_ms = '0;
        push_run(150, 6);
        hold_ask++;
        push_run(100, 6);
        wait_drained();
        push_run(50, 6);
        wait_drained();

        // Low extremes of every register but the wet threshold, which is at its maximum
        set_regs(32'd0, 32'd4095, 32'd0, 32'd0, 32'd0);
        push_run(150, 4);
        wait_drained();

        // High extremes of every register but the wet threshold, which is at zero
        set_regs(32'd4095, 32'd0, 32'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_run(100, 50);
        wait_drained();

        // Random setting, junk in the unused upper data bits
        dry_pick = 12'($urandom_range(1000, 3000));
        set_regs({20'($urandom), dry_pick},
                 {20'($urandom), 12'($urandom_range(500, dry_pick))},
                 {16'($urandom), 16'($urandom_range(1, 30))},
                 32'($urandom_range(20, 200)), 32'($urandom_range(0, 500)));
        push_run(250, 10);
        wait_drained();

        // Final stretch at full rate on both sides
        idle_on = 1'b0;
        set_regs(32'd2000, 32'd1500, 32'd5, 32'd30, 32'd50);
        push_run(250, 8);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0 && outcome_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
